[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the channel FIFO bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define CFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cfbrs_pkg.sv]
// Package with the command codes, status codes and sizes of the channel FIFO bank.
`default_nettype none

package cfbrs_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int DEPTH_DEF    = 4;

    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int CHAN_W    = 3;
    localparam int MASK_W    = 8;
    localparam int STATUS_W  = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH   = 3'd0;
    localparam t_cmd CMD_POP    = 3'd1;
    localparam t_cmd CMD_PEEK   = 3'd2;
    localparam t_cmd CMD_TEST   = 3'd3;
    localparam t_cmd CMD_SELECT = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_NONE  = 2'd3;

endpackage

`default_nettype wire

[rtl/channel_fifo_bank_rr_select_unit.sv]
// Channel FIFO bank with round-robin channel select: command decode, FIFO storage, results.
//
// A bank of CHANNELS FIFOs, DEPTH words of 32 bits each, and a round-robin pointer.
// Every input beat is one command (push, pop, peek, test, select) and yields exactly one
// output beat. A command lands in an input register, is decoded and executed once the
// output register can take its result (pointer and fill-count update, word store write or
// read, rotating priority pick), and its result lands in the output register. One command
// is taken every cycle as long as the output side keeps taking results, and the input
// register can still take one command while a result waits in the output register.
// The word store is a single memory with one write and one registered read
// port; a pop or peek reads it in the execute cycle. Error cases report a status rather
// than blocking: pop on an empty channel gives status empty, push on a full channel drops
// the word and gives status full, select with no masked channel holding data gives status
// none and leaves the pointer alone. A channel index at or above CHANNELS acts as always
// empty and always full. Select scans from one past the last chosen channel and wraps,
// checking the last chosen channel itself last; only channels 0 to 7 have mask bits.
// The word store needs no clearing after reset: a word is read only once written.
`default_nettype none

`include "assert_macros.svh"

module channel_fifo_bank_rr_select_unit #(
    parameter int CHANNELS = cfbrs_pkg::CHANNELS_DEF,
    parameter int DEPTH    = cfbrs_pkg::DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // command channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [cfbrs_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [cfbrs_pkg::CHAN_W-1:0]         i_channel,
    input  wire logic signed [cfbrs_pkg::WORD_W-1:0]  i_data_in,
    input  wire logic [cfbrs_pkg::MASK_W-1:0]         i_mask,
    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [cfbrs_pkg::WORD_W-1:0]       o_data_out,
    output logic [cfbrs_pkg::CHAN_W-1:0]              o_chosen,
    output logic                                      o_has_data,
    output logic [cfbrs_pkg::STATUS_W-1:0]            o_status
);

    localparam int CH_W      = $clog2(CHANNELS);
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MEM_WORDS = CHANNELS * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    // ---------------------------------------------------------------
    // Handshake: the pipeline advances when the output register is free
    // or its beat is taken this cycle.
    // ---------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic adv;
    logic go;
    logic load1;

    assign adv        = !r_v2 || i_out_ready;
    assign o_in_ready = !r_v1 || adv;
    assign load1      = i_in_valid && o_in_ready;
    assign go         = r_v1 && adv;

    // ---------------------------------------------------------------
    // Input register: hold the accepted command beat.
    // ---------------------------------------------------------------
    cfbrs_pkg::t_cmd                 r_cmd;
    logic [cfbrs_pkg::CHAN_W-1:0]    r_channel;
    logic [cfbrs_pkg::WORD_W-1:0]    r_data_in;
    logic [cfbrs_pkg::MASK_W-1:0]    r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= 1'b1;
        end else if (go) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_cmd     <= i_cmd;
            r_channel <= i_channel;
            r_data_in <= i_data_in;
            r_mask    <= i_mask;
        end
    end

    // ---------------------------------------------------------------
    // Per-channel control state.
    // ---------------------------------------------------------------
    logic [PTR_W-1:0] r_head [CHANNELS];
    logic [PTR_W-1:0] r_tail [CHANNELS];
    logic [CNT_W-1:0] r_cnt  [CHANNELS];
    logic [CH_W-1:0]  r_last;

    // Channel index of the command; out-of-range channels never touch state.
    logic [31:0]      ch_wide;
    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [CNT_W-1:0] ch_cnt;
    logic [PTR_W-1:0] ch_head;
    logic [PTR_W-1:0] ch_tail;
    logic             ch_ready;
    logic             ch_room;

    assign ch_wide  = 32'(r_channel);
    assign ch_ok    = ch_wide < 32'(CHANNELS);
    assign ch_idx   = ch_wide[CH_W-1:0];
    assign ch_cnt   = r_cnt[ch_idx];
    assign ch_head  = r_head[ch_idx];
    assign ch_tail  = r_tail[ch_idx];
    assign ch_ready = ch_ok && (ch_cnt != '0);
    assign ch_room  = ch_ok && (ch_cnt < CNT_W'(DEPTH));

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    // ---------------------------------------------------------------
    // Round-robin pick: channels past the pointer first, then wrap to the
    // lowest eligible channel, which may be the pointer itself.
    // ---------------------------------------------------------------
    logic [CHANNELS-1:0] elig;
    logic [CHANNELS-1:0] elig_hi;
    logic [CH_W-1:0]     pick_hi;
    logic [CH_W-1:0]     pick_lo;
    logic                any_hi;
    logic                any_elig;
    logic [CH_W-1:0]     pick;
    logic [31:0]         pick_wide;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            elig[c]    = (c < cfbrs_pkg::MASK_W) && r_mask[c % cfbrs_pkg::MASK_W]
                         && (r_cnt[c] != '0);
            elig_hi[c] = elig[c] && (CH_W'(c) > r_last);
        end
    end

    always_comb begin
        pick_hi = '0;
        pick_lo = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (elig_hi[c]) begin
                pick_hi = CH_W'(c);
            end
            if (elig[c]) begin
                pick_lo = CH_W'(c);
            end
        end
    end

    assign any_hi    = |elig_hi;
    assign any_elig  = |elig;
    assign pick      = any_hi ? pick_hi : pick_lo;
    assign pick_wide = 32'(pick);

    // ---------------------------------------------------------------
    // Command decode.
    // ---------------------------------------------------------------
    logic                         do_push;
    logic                         do_pop;
    logic                         do_read;
    logic                         do_sel;
    logic [cfbrs_pkg::CHAN_W-1:0] n_chosen;
    logic                         n_has_data;
    cfbrs_pkg::t_status           n_status;

    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_read    = 1'b0;
        do_sel     = 1'b0;
        n_chosen   = '0;
        n_has_data = 1'b0;
        n_status   = cfbrs_pkg::ST_OK;
        unique case (r_cmd)
            cfbrs_pkg::CMD_PUSH: begin
                do_push  = ch_room;
                n_status = ch_room ? cfbrs_pkg::ST_OK : cfbrs_pkg::ST_FULL;
            end
            cfbrs_pkg::CMD_POP: begin
                do_pop   = ch_ready;
                do_read  = ch_ready;
                n_status = ch_ready ? cfbrs_pkg::ST_OK : cfbrs_pkg::ST_EMPTY;
            end
            cfbrs_pkg::CMD_PEEK: begin
                do_read = ch_ready;
            end
            cfbrs_pkg::CMD_TEST: begin
                n_has_data = ch_ready;
            end
            cfbrs_pkg::CMD_SELECT: begin
                do_sel   = any_elig;
                n_chosen = any_elig ? pick_wide[cfbrs_pkg::CHAN_W-1:0] : '0;
                n_status = any_elig ? cfbrs_pkg::ST_OK : cfbrs_pkg::ST_NONE;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control state update, taken when the command leaves the input register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
            r_last <= '0;
        end else if (go) begin
            if (do_push) begin
                r_tail[ch_idx] <= wrap_next(ch_tail);
                r_cnt[ch_idx]  <= ch_cnt + 1'b1;
            end
            if (do_pop) begin
                r_head[ch_idx] <= wrap_next(ch_head);
                r_cnt[ch_idx]  <= ch_cnt - 1'b1;
            end
            if (do_sel) begin
                r_last <= pick;
            end
        end
    end

    // ---------------------------------------------------------------
    // Word store: one write port for push, one registered read port for
    // pop and peek. Channel c owns words c*DEPTH to c*DEPTH+DEPTH-1.
    // ---------------------------------------------------------------
    logic [cfbrs_pkg::WORD_W-1:0] mem [MEM_WORDS];
    logic [31:0]                  base;
    logic [31:0]                  waddr_wide;
    logic [31:0]                  raddr_wide;
    logic [ADDR_W-1:0]            waddr;
    logic [ADDR_W-1:0]            raddr;
    logic [cfbrs_pkg::WORD_W-1:0] r_rd_data;

    assign base       = 32'(ch_idx) * 32'(DEPTH);
    assign waddr_wide = base + 32'(ch_tail);
    assign raddr_wide = base + 32'(ch_head);
    assign waddr      = waddr_wide[ADDR_W-1:0];
    assign raddr      = raddr_wide[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (go && do_push) begin
            mem[waddr] <= r_data_in;
        end
        if (go && do_read) begin
            r_rd_data <= mem[raddr];
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until the beat is taken.
    // ---------------------------------------------------------------
    logic                         r_rd_use;
    logic [cfbrs_pkg::CHAN_W-1:0] r_chosen;
    logic                         r_has_data;
    cfbrs_pkg::t_status           r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rd_use   <= do_read;
            r_chosen   <= n_chosen;
            r_has_data <= n_has_data;
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_v2;
    assign o_data_out  = r_rd_use ? $signed(r_rd_data) : '0;
    assign o_chosen    = r_chosen;
    assign o_has_data  = r_has_data;
    assign o_status    = r_status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic cnt_over;

    always_comb begin
        cnt_over = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_cnt[c] > CNT_W'(DEPTH)) begin
                cnt_over = 1'b1;
            end
        end
    end

    `CFB_ASSERT(a_cnt_bound, i_clk, i_rst_n, !cnt_over, "fill count above depth")
    `CFB_ASSERT(a_pop_dec, i_clk, i_rst_n,
        (go && do_pop) |=> (r_cnt[$past(ch_idx)] == $past(ch_cnt) - 1'b1),
        "pop did not drop the fill count")
    `CFB_ASSERT(a_sel_none_hold, i_clk, i_rst_n,
        (go && r_cmd == cfbrs_pkg::CMD_SELECT && !any_elig) |=> $stable(r_last),
        "select with nothing ready moved the pointer")
    `CFB_ASSERT_ALWAYS(a_ready_free, i_clk, (i_rst_n && !r_v2) |-> o_in_ready,
        "input stalled with the output register empty")

endmodule

`default_nettype wire
